FILE: sv/flms_pkg.sv
// shared types and constants for the launch mode supervisor
package flms_pkg;

  localparam int unsigned FLMS_QUEUE_DEPTH = 4;

  localparam logic [14:0] GROUND_BAND_RST  = 15'd26;
  localparam logic [31:0] ACCEL_LIMIT_RST  = 32'd16384;
  localparam logic [31:0] RATE_LIMIT_RST   = 32'd16384;
  localparam logic [31:0] SPEED_LIMIT_RST  = 32'd16384;
  localparam logic [3:0]  FALL_TICKS_RST   = 4'd10;
  localparam logic [3:0]  STEADY_TICKS_RST = 4'd5;

  typedef enum logic [2:0] {
    REG_GROUND_BAND  = 3'd0,
    REG_ACCEL_LIMIT  = 3'd1,
    REG_RATE_LIMIT   = 3'd2,
    REG_SPEED_LIMIT  = 3'd3,
    REG_FALL_TICKS   = 3'd4,
    REG_STEADY_TICKS = 3'd5
  } flms_reg_e;

  typedef struct packed {
    logic [14:0] ground_band;
    logic [31:0] accel_limit_sq;
    logic [31:0] rate_limit_sq;
    logic [31:0] speed_limit_sq;
    logic [3:0]  fall_ticks;
    logic [3:0]  steady_ticks;
  } flms_cfg_t;

  // per-sample classification handed from front to back
  typedef struct packed {
    logic near_ground;
    logic low_acc;
    logic low_rate;
    logic low_vel;
  } flms_class_t;

endpackage

FILE: sv/flms_front.sv
// front end: squares each vector, then classifies the sample against the limits
module flms_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [15:0]  height_i,
  input  logic signed [15:0]  acc_x_i,
  input  logic signed [15:0]  acc_y_i,
  input  logic signed [15:0]  acc_z_i,
  input  logic signed [15:0]  rate_x_i,
  input  logic signed [15:0]  rate_y_i,
  input  logic signed [15:0]  rate_z_i,
  input  logic signed [15:0]  vel_x_i,
  input  logic signed [15:0]  vel_y_i,
  input  logic signed [15:0]  vel_z_i,
  input  flms_pkg::flms_cfg_t cfg_i,
  output logic                cls_valid_o,
  input  logic                cls_ready_i,
  output flms_pkg::flms_class_t cls_o
);
  import flms_pkg::*;

  logic signed [31:0] ax_sq, ay_sq, az_sq;
  logic signed [31:0] rx_sq, ry_sq, rz_sq;
  logic signed [31:0] vx_sq, vy_sq, vz_sq;
  logic [31:0] acc_sum, rate_sum, vel_sum;
  logic [15:0] habs;
  logic        take;

  logic        stg_valid_q;
  logic [31:0] acc_sum_q, rate_sum_q, vel_sum_q;
  logic [15:0] habs_q;

  assign ax_sq = 32'(acc_x_i) * 32'(acc_x_i);
  assign ay_sq = 32'(acc_y_i) * 32'(acc_y_i);
  assign az_sq = 32'(acc_z_i) * 32'(acc_z_i);
  assign rx_sq = 32'(rate_x_i) * 32'(rate_x_i);
  assign ry_sq = 32'(rate_y_i) * 32'(rate_y_i);
  assign rz_sq = 32'(rate_z_i) * 32'(rate_z_i);
  assign vx_sq = 32'(vel_x_i) * 32'(vel_x_i);
  assign vy_sq = 32'(vel_y_i) * 32'(vel_y_i);
  assign vz_sq = 32'(vel_z_i) * 32'(vel_z_i);

  // each square is at most 2^30, so three of them fit in 32 bits
  assign acc_sum  = unsigned'(ax_sq) + unsigned'(ay_sq) + unsigned'(az_sq);
  assign rate_sum = unsigned'(rx_sq) + unsigned'(ry_sq) + unsigned'(rz_sq);
  assign vel_sum  = unsigned'(vx_sq) + unsigned'(vy_sq) + unsigned'(vz_sq);

  // most negative height gives 16'h8000, read unsigned as 32768
  assign habs = height_i[15] ? 16'(-height_i) : 16'(height_i);

  assign in_ready_o = !stg_valid_q || cls_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      stg_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      acc_sum_q  <= acc_sum;
      rate_sum_q <= rate_sum;
      vel_sum_q  <= vel_sum;
      habs_q     <= habs;
    end
  end

  assign cls_valid_o       = stg_valid_q;
  assign cls_o.near_ground = habs_q < {1'b0, cfg_i.ground_band};
  assign cls_o.low_acc     = acc_sum_q < cfg_i.accel_limit_sq;
  assign cls_o.low_rate    = rate_sum_q < cfg_i.rate_limit_sq;
  assign cls_o.low_vel     = vel_sum_q < cfg_i.speed_limit_sq;

endmodule

FILE: sv/flms_queue.sv
// small queue of classified samples between front and back
module flms_queue #(
  parameter int unsigned Depth = flms_pkg::FLMS_QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_valid_i,
  output logic                  wr_ready_o,
  input  flms_pkg::flms_class_t wr_data_i,
  output logic                  rd_valid_o,
  input  logic                  rd_ready_i,
  output flms_pkg::flms_class_t rd_data_o
);
  import flms_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  flms_class_t         mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                push, pop;

  assign wr_ready_o = count_q != CntW'(Depth);
  assign rd_valid_o = count_q != '0;
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

FILE: sv/flms_back.sv
// back end: run counters and the launch mode sequencer, with output register
module flms_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cls_valid_i,
  output logic                  cls_ready_o,
  input  flms_pkg::flms_class_t cls_i,
  input  logic [3:0]            fall_ticks_i,
  input  logic [3:0]            steady_ticks_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            flight_mode_o,
  output logic                  free_fall_o
);
  import flms_pkg::*;

  typedef enum logic [1:0] {
    MODE_READY     = 2'd0,
    MODE_ATTITUDE  = 2'd1,
    MODE_STABILISE = 2'd2,
    MODE_HOLD      = 2'd3
  } mode_e;

  mode_e       mode_q, mode_d;
  mode_e       mode_gnd, mode_fall, mode_steady;
  logic [3:0]  fall_run_q, fall_run_d;
  logic [3:0]  steady_run_q, steady_run_d;
  logic        out_valid_q;
  logic [1:0]  flight_mode_q;
  logic        free_fall_q;
  logic        pop;

  assign cls_ready_o = !out_valid_q || out_ready_i;
  assign pop         = cls_valid_i && cls_ready_o;

  // checks in order, each one sees the mode the previous one left
  always_comb begin
    mode_gnd = cls_i.near_ground ? MODE_READY : mode_q;

    if (cls_i.low_acc) begin
      fall_run_d = (fall_run_q == 4'hF) ? 4'hF : fall_run_q + 4'd1;
    end else begin
      fall_run_d = 4'd0;
    end
    mode_fall = (fall_run_d >= fall_ticks_i) ? MODE_ATTITUDE : mode_gnd;

    if (mode_fall == MODE_ATTITUDE && cls_i.low_rate) begin
      steady_run_d = (steady_run_q == 4'hF) ? 4'hF : steady_run_q + 4'd1;
    end else begin
      steady_run_d = 4'd0;
    end
    mode_steady = (steady_run_d >= steady_ticks_i) ? MODE_STABILISE : mode_fall;

    mode_d = (mode_steady == MODE_STABILISE && cls_i.low_vel) ? MODE_HOLD : mode_steady;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_READY;
      fall_run_q    <= 4'd0;
      steady_run_q  <= 4'd0;
      out_valid_q   <= 1'b0;
      flight_mode_q <= 2'd0;
      free_fall_q   <= 1'b0;
    end else begin
      if (pop) begin
        mode_q        <= mode_d;
        fall_run_q    <= fall_run_d;
        steady_run_q  <= steady_run_d;
        flight_mode_q <= mode_d;
        free_fall_q   <= cls_i.low_acc;
        out_valid_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign flight_mode_o = flight_mode_q;
  assign free_fall_o   = free_fall_q;

endmodule

FILE: sv/freefall_launch_mode_supervisor.sv
// launch mode supervisor: config registers, front classifier, queue, mode sequencer
//
//   channel  | valid / ready          | payload
//   ---------+------------------------+------------------------------------------
//   sample   | in_valid_i / in_ready_o   | height_i, acc_*_i, rate_*_i, vel_*_i
//   result   | out_valid_o / out_ready_i | flight_mode_o, free_fall_o
//   config   | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// one sample per cycle sustained while the result side keeps up; a sample word
// reaches the result word through the front stage register, the queue and the
// output register of the mode sequencer; async active-low reset clears modes, run
// counters and queue; config regs return to their defaults; config is always ready
// a stalled result stops the sequencer; the front fills the queue until it is full
module freefall_launch_mode_supervisor #(
  parameter int unsigned QueueDepth = flms_pkg::FLMS_QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] height_i,
  input  logic signed [15:0] acc_x_i,
  input  logic signed [15:0] acc_y_i,
  input  logic signed [15:0] acc_z_i,
  input  logic signed [15:0] rate_x_i,
  input  logic signed [15:0] rate_y_i,
  input  logic signed [15:0] rate_z_i,
  input  logic signed [15:0] vel_x_i,
  input  logic signed [15:0] vel_y_i,
  input  logic signed [15:0] vel_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         flight_mode_o,
  output logic               free_fall_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import flms_pkg::*;

  flms_cfg_t   cfg_q;
  logic        fr_valid, fr_ready;
  flms_class_t fr_cls;
  logic        bk_valid, bk_ready;
  flms_class_t bk_cls;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ground_band    <= GROUND_BAND_RST;
      cfg_q.accel_limit_sq <= ACCEL_LIMIT_RST;
      cfg_q.rate_limit_sq  <= RATE_LIMIT_RST;
      cfg_q.speed_limit_sq <= SPEED_LIMIT_RST;
      cfg_q.fall_ticks     <= FALL_TICKS_RST;
      cfg_q.steady_ticks   <= STEADY_TICKS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_GROUND_BAND:  cfg_q.ground_band    <= cfg_data_i[14:0];
        REG_ACCEL_LIMIT:  cfg_q.accel_limit_sq <= cfg_data_i;
        REG_RATE_LIMIT:   cfg_q.rate_limit_sq  <= cfg_data_i;
        REG_SPEED_LIMIT:  cfg_q.speed_limit_sq <= cfg_data_i;
        REG_FALL_TICKS:   cfg_q.fall_ticks     <= cfg_data_i[3:0];
        REG_STEADY_TICKS: cfg_q.steady_ticks   <= cfg_data_i[3:0];
        default: ;  // unknown index, word dropped
      endcase
    end
  end

  flms_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .height_i    (height_i),
    .acc_x_i     (acc_x_i),
    .acc_y_i     (acc_y_i),
    .acc_z_i     (acc_z_i),
    .rate_x_i    (rate_x_i),
    .rate_y_i    (rate_y_i),
    .rate_z_i    (rate_z_i),
    .vel_x_i     (vel_x_i),
    .vel_y_i     (vel_y_i),
    .vel_z_i     (vel_z_i),
    .cfg_i       (cfg_q),
    .cls_valid_o (fr_valid),
    .cls_ready_i (fr_ready),
    .cls_o       (fr_cls)
  );

  flms_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_data_i  (fr_cls),
    .rd_valid_o (bk_valid),
    .rd_ready_i (bk_ready),
    .rd_data_o  (bk_cls)
  );

  flms_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cls_valid_i    (bk_valid),
    .cls_ready_o    (bk_ready),
    .cls_i          (bk_cls),
    .fall_ticks_i   (cfg_q.fall_ticks),
    .steady_ticks_i (cfg_q.steady_ticks),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .flight_mode_o  (flight_mode_o),
    .free_fall_o    (free_fall_o)
  );

endmodule

FILE: sv/flms_checker.sv
// port-level checks for the launch mode supervisor, bound to the top level
module flms_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [1:0]         flight_mode_o,
  input logic               free_fall_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o
);
  import flms_pkg::*;

  logic [4:0] pending_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // words taken in but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 5'd1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 5'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(flight_mode_o) && $stable(free_fall_o))
    else $error("result word changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 5'd0)
    else $error("result word with no sample outstanding");

  a_ready_backed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> pending_q != 5'd0)
    else $error("input stalled with nothing in flight");

  a_cfg_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write refused");

endmodule

bind freefall_launch_mode_supervisor flms_checker u_flms_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .flight_mode_o (flight_mode_o),
  .free_fall_o   (free_fall_o),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o)
);

FILE: sim/tb_freefall_launch_mode_supervisor.sv
// testbench for the launch mode supervisor: sensor words checked against a mode predictor
module tb_freefall_launch_mode_supervisor;
  import flms_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [2:0]  REG_SPARE_LO = 3'd6;
  localparam logic [2:0]  REG_SPARE_HI = 3'd7;
  localparam logic [3:0]  RUN_MAX      = 4'd15;

  typedef enum logic [1:0] {
    MODE_READY     = 2'd0,
    MODE_ATTITUDE  = 2'd1,
    MODE_STABILISE = 2'd2,
    MODE_HOLD      = 2'd3
  } launch_mode_e;

  typedef logic [2:0][15:0] axis3_t;

  typedef struct packed {
    logic [15:0] height;
    axis3_t      acc;
    axis3_t      rate;
    axis3_t      vel;
  } sensor_word_t;

  typedef struct packed {
    launch_mode_e mode;
    logic         free_fall;
  } mode_word_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] height_i = '0;
  logic signed [15:0] acc_x_i = '0, acc_y_i = '0, acc_z_i = '0;
  logic signed [15:0] rate_x_i = '0, rate_y_i = '0, rate_z_i = '0;
  logic signed [15:0] vel_x_i = '0, vel_y_i = '0, vel_z_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         flight_mode_o;
  logic               free_fall_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;

  // predictor copy of the registers and the sequencer state
  logic [14:0]  band_q        = GROUND_BAND_RST;
  logic [31:0]  acc_lim_q     = ACCEL_LIMIT_RST;
  logic [31:0]  rate_lim_q    = RATE_LIMIT_RST;
  logic [31:0]  speed_lim_q   = SPEED_LIMIT_RST;
  logic [3:0]   fall_need_q   = FALL_TICKS_RST;
  logic [3:0]   steady_need_q = STEADY_TICKS_RST;
  launch_mode_e mode_q        = MODE_READY;
  logic [3:0]   fall_run_q    = '0;
  logic [3:0]   steady_run_q  = '0;

  mode_word_t  expected_modes[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;

  freefall_launch_mode_supervisor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .height_i      (height_i),
    .acc_x_i       (acc_x_i),
    .acc_y_i       (acc_y_i),
    .acc_z_i       (acc_z_i),
    .rate_x_i      (rate_x_i),
    .rate_y_i      (rate_y_i),
    .rate_z_i      (rate_z_i),
    .vel_x_i       (vel_x_i),
    .vel_y_i       (vel_y_i),
    .vel_z_i       (vel_z_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .flight_mode_o (flight_mode_o),
    .free_fall_o   (free_fall_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic logic [33:0] sq_magnitude(axis3_t v);
    logic [33:0]        total;
    logic signed [31:0] c;
    int                 i;
    total = '0;
    for (i = 0; i < 3; i++) begin
      c = $signed(v[i]);
      total += 34'(c * c);
    end
    return total;
  endfunction

  function automatic mode_word_t advance_mode(sensor_word_t s);
    int         hmag;
    logic       low_acc, low_rate, low_vel;
    mode_word_t w;
    hmag = $signed(s.height);
    if (hmag < 0) hmag = -hmag;
    low_acc  = sq_magnitude(s.acc) < {2'b00, acc_lim_q};
    low_rate = sq_magnitude(s.rate) < {2'b00, rate_lim_q};
    low_vel  = sq_magnitude(s.vel) < {2'b00, speed_lim_q};

    if (hmag < int'(band_q)) mode_q = MODE_READY;

    if (low_acc) fall_run_q = (fall_run_q == RUN_MAX) ? RUN_MAX : fall_run_q + 4'd1;
    else fall_run_q = '0;
    if (fall_run_q >= fall_need_q) mode_q = MODE_ATTITUDE;

    if (mode_q == MODE_ATTITUDE && low_rate) begin
      steady_run_q = (steady_run_q == RUN_MAX) ? RUN_MAX : steady_run_q + 4'd1;
    end else begin
      steady_run_q = '0;
    end
    if (steady_run_q >= steady_need_q) mode_q = MODE_STABILISE;

    if (mode_q == MODE_STABILISE && low_vel) mode_q = MODE_HOLD;

    w.mode = mode_q;
    w.free_fall = low_acc;
    return w;
  endfunction

  function automatic void apply_reg_write(logic [2:0] idx, logic [31:0] data);
    unique case (idx)
      REG_GROUND_BAND:  band_q = data[14:0];
      REG_ACCEL_LIMIT:  acc_lim_q = data;
      REG_RATE_LIMIT:   rate_lim_q = data;
      REG_SPEED_LIMIT:  speed_lim_q = data;
      REG_FALL_TICKS:   fall_need_q = data[3:0];
      REG_STEADY_TICKS: steady_need_q = data[3:0];
      default: ;
    endcase
  endfunction

  function automatic sensor_word_t port_word();
    sensor_word_t s;
    s.height = height_i;
    s.acc[0] = acc_x_i;
    s.acc[1] = acc_y_i;
    s.acc[2] = acc_z_i;
    s.rate[0] = rate_x_i;
    s.rate[1] = rate_y_i;
    s.rate[2] = rate_z_i;
    s.vel[0] = vel_x_i;
    s.vel[1] = vel_y_i;
    s.vel[2] = vel_z_i;
    return s;
  endfunction

  task automatic note_mismatch(string what, int want_v, int got_v);
    mismatch_count++;
    $display("%0t %s: expected %0d, actual %0d", $time, what, want_v, got_v);
  endtask

  task automatic check_word();
    mode_word_t want;
    if (expected_modes.size() == 0) begin
      // -1 marks that no word was expected
      note_mismatch("result word with nothing expected", -1, flight_mode_o);
    end else begin
      want = expected_modes.pop_front();
      if (want.mode !== flight_mode_o)
        note_mismatch("flight_mode", want.mode, flight_mode_o);
      if (want.free_fall !== free_fall_o)
        note_mismatch("free_fall", want.free_fall, free_fall_o);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_q = GROUND_BAND_RST;
      acc_lim_q = ACCEL_LIMIT_RST;
      rate_lim_q = RATE_LIMIT_RST;
      speed_lim_q = SPEED_LIMIT_RST;
      fall_need_q = FALL_TICKS_RST;
      steady_need_q = STEADY_TICKS_RST;
      mode_q = MODE_READY;
      fall_run_q = '0;
      steady_run_q = '0;
      expected_modes.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) apply_reg_write(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) expected_modes.push_back(advance_mode(port_word()));
      if (out_valid_o && out_ready_i) check_word();
    end
  end

  task automatic offer_sample(sensor_word_t s);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct && gap < 40) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    height_i <= s.height;
    acc_x_i <= s.acc[0];
    acc_y_i <= s.acc[1];
    acc_z_i <= s.acc[2];
    rate_x_i <= s.rate[0];
    rate_y_i <= s.rate[1];
    rate_z_i <= s.rate[2];
    vel_x_i <= s.vel[0];
    vel_y_i <= s.vel[1];
    vel_z_i <= s.vel[2];
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_config(logic [31:0] band, logic [31:0] acc, logic [31:0] rate,
                              logic [31:0] speed, logic [31:0] fall, logic [31:0] steady);
    write_reg(REG_GROUND_BAND, band);
    write_reg(REG_ACCEL_LIMIT, acc);
    write_reg(REG_RATE_LIMIT, rate);
    write_reg(REG_SPEED_LIMIT, speed);
    write_reg(REG_FALL_TICKS, fall);
    write_reg(REG_STEADY_TICKS, steady);
  endtask

  // stop offering and let every expected word drain out of the pipeline
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (expected_modes.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  function automatic int unsigned isqrt(logic [31:0] v);
    int unsigned       r;
    longint unsigned   t;
    int                b;
    r = 0;
    for (b = 15; b >= 0; b--) begin
      t = r | (32'd1 << b);
      if (t * t <= v) r = r | (32'd1 << b);
    end
    return r;
  endfunction

  function automatic axis3_t make_vec(bit want_low, logic [31:0] limit);
    axis3_t      v;
    int unsigned m;
    int          c, i;
    if (want_low && limit != 0) begin
      m = isqrt((limit - 32'd1) / 32'd3);
      if (m > 32767) m = 32767;
      for (i = 0; i < 3; i++) v[i] = 16'(int'($urandom_range(2 * m)) - int'(m));
    end else if ($urandom_range(9) < 3) begin
      // one component right around the threshold, the rest zero
      c = int'(isqrt(limit)) + int'($urandom_range(4)) - 2;
      if (c < 0) c = 0;
      if (c > 32767) c = 32767;
      v = '0;
      v[$urandom_range(2)] = $urandom_range(1) ? 16'(-c) : 16'(c);
    end else begin
      for (i = 0; i < 3; i++) v[i] = 16'($urandom);
    end
    return v;
  endfunction

  function automatic sensor_word_t make_sample(bit grounded, bit low_acc, bit low_rate,
                                               bit low_vel);
    sensor_word_t s;
    int           band, h;
    band = int'(band_q);
    if (grounded && band > 0) begin
      h = int'($urandom_range(2 * (band - 1))) - (band - 1);
    end else if (grounded) begin
      h = 0;
    end else if ($urandom_range(19) == 0) begin
      h = -32768;
    end else begin
      h = band + int'($urandom_range(32767 - band));
      if ($urandom_range(1)) h = -h;
    end
    s.height = 16'(h);
    s.acc = make_vec(low_acc, acc_lim_q);
    s.rate = make_vec(low_rate, rate_lim_q);
    s.vel = make_vec(low_vel, speed_lim_q);
    return s;
  endfunction

  function automatic sensor_word_t noise_sample();
    sensor_word_t s;
    int           i;
    s.height = 16'($urandom);
    for (i = 0; i < 3; i++) begin
      s.acc[i] = 16'($urandom);
      s.rate[i] = 16'($urandom);
      s.vel[i] = 16'($urandom);
    end
    return s;
  endfunction

  function automatic sensor_word_t pack_sample(logic [15:0] h, logic [15:0] ax, logic [15:0] ay,
                                               logic [15:0] az, logic [15:0] rx, logic [15:0] ry,
                                               logic [15:0] rz, logic [15:0] vx, logic [15:0] vy,
                                               logic [15:0] vz);
    sensor_word_t s;
    s.height = h;
    s.acc = {az, ay, ax};
    s.rate = {rz, ry, rx};
    s.vel = {vz, vy, vx};
    return s;
  endfunction

  // one launch: maybe a few ground words, a free-fall run, then a ride with mixed rates
  task automatic fly_once(output int n);
    int fall_len, ride_len, k;
    n = 0;
    fall_len = $urandom_range(20);
    ride_len = $urandom_range(10);
    repeat ($urandom_range(2)) begin
      offer_sample(make_sample(1'b1, $urandom_range(1), $urandom_range(1), $urandom_range(1)));
      n++;
    end
    for (k = 0; k < fall_len; k++) begin
      offer_sample(make_sample($urandom_range(49) == 0, 1'b1, $urandom_range(9) < 8,
                               $urandom_range(9) < 3));
      n++;
    end
    for (k = 0; k < ride_len; k++) begin
      offer_sample(make_sample($urandom_range(29) == 0, $urandom_range(9) == 0,
                               $urandom_range(9) < 7, $urandom_range(1)));
      n++;
    end
  endtask

  task automatic run_traffic(int n_items);
    int sent, k;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 15) begin
        offer_sample(noise_sample());
        sent++;
      end else begin
        fly_once(k);
        sent += k;
      end
    end
  endtask

  task automatic test_directed_cases();
    int k;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    offer_sample(pack_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                             16'h8000, 16'h8000, 16'h8000, 16'h8000));
    offer_sample(pack_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                             16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    // ground band edges and the squared-magnitude threshold, both sides
    offer_sample(pack_sample(16'd25, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    offer_sample(pack_sample(-16'sd25, 16'd127, 0, 0, 0, 0, 0, 0, 0, 0));
    offer_sample(pack_sample(16'd26, 16'd128, 0, 0, 0, 0, 16'd128, 0, 16'd128, 0));
    offer_sample(pack_sample(-16'sd26, 0, -16'sd127, 0, 0, 0, 0, 0, 0, 0));
    for (k = 0; k < 12; k++)
      offer_sample(pack_sample(16'd2000, 0, 0, -16'sd127, (k < 8) ? 16'd300 : 16'd0, 0,
                               16'd100, 16'd400, 0, 0));
    for (k = 0; k < 6; k++)
      offer_sample(pack_sample(16'd2000, 0, 0, 16'd2560, 0, 16'd90, 0,
                               (k < 3) ? 16'd200 : 16'd60, 0, 0));
  endtask

  task automatic test_register_masking();
    wait_for_results();
    // upper bits must be dropped; zero tick counts; spare indexes ignored
    write_reg(REG_GROUND_BAND, 32'hABCD_0040);
    write_reg(REG_ACCEL_LIMIT, 32'h0000_4000);
    write_reg(REG_RATE_LIMIT, 32'h0001_0000);
    write_reg(REG_SPEED_LIMIT, 32'h0000_2000);
    write_reg(REG_FALL_TICKS, 32'hFFFF_FFF0);
    write_reg(REG_STEADY_TICKS, 32'h0000_0010);
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, $urandom);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    run_traffic(100);
  endtask

  task automatic test_random_flights(int unsigned tx_pct, int unsigned rx_pct,
                                     logic [31:0] band, logic [31:0] acc, logic [31:0] rate,
                                     logic [31:0] speed, logic [31:0] fall, logic [31:0] steady);
    wait_for_results();
    write_config(band, acc, rate, speed, fall, steady);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    run_traffic(320);
  endtask

  task automatic test_backpressure();
    wait_for_results();
    write_config(32'd26, 32'd16384, 32'd16384, 32'd16384, 32'd3, 32'd2);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_request = 300;
    run_traffic(60);
    // sender pauses until every word is back
    wait_for_results();
    tx_idle_pct = 25;
    rx_stall_pct = 25;
    run_traffic(60);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_register_masking();
    test_random_flights(0, 0, 32'd26, 32'd16384, 32'd16384, 32'd16384, 32'd10, 32'd5);
    test_random_flights(72, 0, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd15, 32'd15);
    test_random_flights(0, 72, 32'd32767, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1);
    test_random_flights(25, 25, $urandom_range(600), $urandom_range(32'h0010_0000),
                        $urandom_range(32'h0010_0000), $urandom_range(32'h0010_0000),
                        $urandom, $urandom);
    test_backpressure();
    wait_for_results();
    if (mismatch_count == 0 && expected_modes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
